// ===== rtl/core/sha1_pkg.sv =====
`default_nettype none

package sha1_pkg;

  // Initial chaining words H0..H4
  localparam logic [31:0] H_INIT [5] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
  };

  // Round constants, one per group of twenty rounds
  localparam logic [31:0] K_R0 = 32'h5A827999;
  localparam logic [31:0] K_R1 = 32'h6ED9EBA1;
  localparam logic [31:0] K_R2 = 32'h8F1BBCDC;
  localparam logic [31:0] K_R3 = 32'hCA62C1D6;

  // Padding marker byte
  localparam logic [7:0] PAD_MARK = 8'h80;

  // Word indexes within a 16-word block used by the padder
  localparam logic [3:0] LEN_HI_SLOT = 4'd14;
  localparam logic [3:0] LAST_SLOT   = 4'd15;
  localparam logic [3:0] PRE_LEN_SLOT = 4'd13;

  // One block word moving from the padder to the compression core
  typedef struct packed {
    logic [31:0] word;
    logic        msg_end;  // last word of the final block of a message
  } sha1_qword_t;

endpackage

`default_nettype wire

// ===== rtl/core/sha1_in_if.sv =====
`default_nettype none

interface sha1_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] msg_byte;
  logic       byte_valid;
  logic       last_byte;

  modport source (output valid, output msg_byte, output byte_valid, output last_byte,
                  input ready);
  modport sink   (input valid, input msg_byte, input byte_valid, input last_byte,
                  output ready);
endinterface

`default_nettype wire

// ===== rtl/core/sha1_out_if.sv =====
`default_nettype none

interface sha1_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  modport source (output valid, output digest_word, output word_index, output last_word,
                  input ready);
  modport sink   (input valid, input digest_word, input word_index, input last_word,
                  output ready);
endinterface

`default_nettype wire

// ===== rtl/core/sha1_queue.sv =====
`default_nettype none

module sha1_queue #(
  parameter int DEPTH = 4
) (
  input  wire                        clk,
  input  wire                        rst,
  input  wire                        push,
  input  wire sha1_pkg::sha1_qword_t push_data,
  output logic                       full,
  input  wire                        pop,
  output logic                       q_valid,
  output sha1_pkg::sha1_qword_t      q_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  sha1_pkg::sha1_qword_t entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  logic do_push;
  logic do_pop;

  assign full    = (count == FULL_CNT);
  assign q_valid = (count != '0);
  assign q_data  = entries[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && q_valid;

  // Storage, no reset needed
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/sha1_front.sv =====
`default_nettype none

// Byte packer and padder: turns the byte stream into 32-bit block words.
module sha1_front (
  input  wire                   clk,
  input  wire                   rst,
  sha1_in_if.sink               in_ch,
  input  wire                   q_full,
  output logic                  push,
  output sha1_pkg::sha1_qword_t push_data
);

  typedef enum logic [2:0] {
    ST_TAKE,
    ST_MARK,
    ST_ZERO,
    ST_LEN_HI,
    ST_LEN_LO
  } state_t;

  state_t      state;
  logic [63:0] len;      // message bytes so far
  logic [23:0] acc;      // bytes of the word being packed
  logic [3:0]  pad_wi;   // block word index while padding
  logic        len_ok;   // length may go into slots 14/15 of this block
  logic        take;
  logic [31:0] mark_word;

  assign in_ch.ready = (state == ST_TAKE) && !q_full;
  assign take        = in_ch.valid && in_ch.ready;

  // Partial word closed with the padding marker
  always_comb begin
    unique case (len[1:0])
      2'd0:    mark_word = {sha1_pkg::PAD_MARK, 24'h0};
      2'd1:    mark_word = {acc[7:0], sha1_pkg::PAD_MARK, 16'h0};
      2'd2:    mark_word = {acc[15:0], sha1_pkg::PAD_MARK, 8'h0};
      default: mark_word = {acc[23:0], sha1_pkg::PAD_MARK};
    endcase
  end

  // Word pushed into the queue
  always_comb begin
    push              = 1'b0;
    push_data.word    = 32'h0;
    push_data.msg_end = 1'b0;
    unique case (state)
      ST_TAKE: begin
        push           = take && in_ch.byte_valid && (len[1:0] == 2'd3);
        push_data.word = {acc, in_ch.msg_byte};
      end
      ST_MARK: begin
        push           = !q_full;
        push_data.word = mark_word;
      end
      ST_ZERO: begin
        push = !q_full;
      end
      ST_LEN_HI: begin
        push           = !q_full;
        push_data.word = len[60:29];
      end
      default: begin
        push              = !q_full;
        push_data.word    = {len[28:0], 3'b000};
        push_data.msg_end = 1'b1;
      end
    endcase
  end

  // Packer state and padding sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_TAKE;
      len    <= 64'h0;
      pad_wi <= 4'h0;
      len_ok <= 1'b0;
    end else begin
      unique case (state)
        ST_TAKE: begin
          if (take) begin
            if (in_ch.byte_valid) begin
              len <= len + 64'd1;
              acc <= {acc[15:0], in_ch.msg_byte};
            end
            if (in_ch.last_byte) begin
              state <= ST_MARK;
            end
          end
        end
        ST_MARK: begin
          if (push) begin
            pad_wi <= len[5:2] + 4'd1;
            len_ok <= (len[5:2] != sha1_pkg::LEN_HI_SLOT);
            state  <= (len[5:2] == sha1_pkg::PRE_LEN_SLOT) ? ST_LEN_HI : ST_ZERO;
          end
        end
        ST_ZERO: begin
          if (push) begin
            pad_wi <= pad_wi + 4'd1;
            // wrapping into a fresh block leaves room for the length
            if (pad_wi == sha1_pkg::LAST_SLOT) begin
              len_ok <= 1'b1;
            end
            if (pad_wi == sha1_pkg::PRE_LEN_SLOT && len_ok) begin
              state <= ST_LEN_HI;
            end
          end
        end
        ST_LEN_HI: begin
          if (push) begin
            state <= ST_LEN_LO;
          end
        end
        default: begin
          if (push) begin
            len   <= 64'h0;
            state <= ST_TAKE;
          end
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/sha1_back.sv =====
`default_nettype none

// Core: one round per cycle unless waiting for a queue word; 16-word schedule line.
module sha1_back (
  input  wire                        clk,
  input  wire                        rst,
  input  wire                        q_valid,
  input  wire sha1_pkg::sha1_qword_t q_data,
  output logic                       pop,
  sha1_out_if.source                 out_ch
);

  localparam logic [6:0] LAST_ROUND = 7'd79;
  localparam logic [6:0] LOAD_END   = 7'd16;
  localparam logic [6:0] LOAD_LAST  = 7'd15;
  localparam logic [2:0] LAST_IDX   = 3'd4;

  typedef enum logic [1:0] {
    ST_ROUND,
    ST_FOLD,
    ST_EMIT
  } state_t;

  state_t      state;
  logic [6:0]  rnd;
  logic [31:0] a, b, c, d, e;
  logic [31:0] h [5];
  logic [31:0] w [16];       // w[15] is the newest schedule word
  logic        msg_end;
  logic [2:0]  oidx;
  logic        out_valid;
  logic [31:0] out_word;
  logic [2:0]  out_index;
  logic        out_last;

  logic        need_q;
  logic        step;
  logic [31:0] sched_x;
  logic [31:0] wt;
  logic [31:0] f;
  logic [31:0] k;
  logic [31:0] tmp;

  assign need_q = (rnd < LOAD_END);
  assign step   = (state == ST_ROUND) && (!need_q || q_valid);
  assign pop    = step && need_q;

  // Schedule word: from the queue for the first sixteen rounds
  assign sched_x = w[13] ^ w[8] ^ w[2] ^ w[0];
  assign wt      = need_q ? q_data.word : {sched_x[30:0], sched_x[31]};

  // Round function and constant
  always_comb begin
    if (rnd < 7'd20) begin
      f = (b & c) | (~b & d);
      k = sha1_pkg::K_R0;
    end else if (rnd < 7'd40) begin
      f = b ^ c ^ d;
      k = sha1_pkg::K_R1;
    end else if (rnd < 7'd60) begin
      f = (b & c) | (b & d) | (c & d);
      k = sha1_pkg::K_R2;
    end else begin
      f = b ^ c ^ d;
      k = sha1_pkg::K_R3;
    end
  end

  assign tmp = {a[26:0], a[31:27]} + f + e + wt + k;

  // Schedule shift line
  always_ff @(posedge clk) begin
    if (step) begin
      for (int i = 0; i < 15; i++) begin
        w[i] <= w[i+1];
      end
      w[15] <= wt;
    end
  end

  // Digest output register, payload only
  always_ff @(posedge clk) begin
    if (state == ST_EMIT && (!out_valid || out_ch.ready)) begin
      out_word  <= h[oidx];
      out_index <= oidx;
      out_last  <= (oidx == LAST_IDX);
    end
  end

  // Round sequencer, chaining state and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_ROUND;
      rnd       <= 7'd0;
      msg_end   <= 1'b0;
      oidx      <= 3'd0;
      out_valid <= 1'b0;
      a <= sha1_pkg::H_INIT[0];
      b <= sha1_pkg::H_INIT[1];
      c <= sha1_pkg::H_INIT[2];
      d <= sha1_pkg::H_INIT[3];
      e <= sha1_pkg::H_INIT[4];
      for (int i = 0; i < 5; i++) begin
        h[i] <= sha1_pkg::H_INIT[i];
      end
    end else begin
      // while emitting, the emit arm decides the output valid
      if (out_valid && out_ch.ready && state != ST_EMIT) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_ROUND: begin
          if (step) begin
            e <= d;
            d <= c;
            c <= {b[1:0], b[31:2]};
            b <= a;
            a <= tmp;
            if (rnd == LOAD_LAST) begin
              msg_end <= q_data.msg_end;
            end
            if (rnd == LAST_ROUND) begin
              rnd   <= 7'd0;
              state <= ST_FOLD;
            end else begin
              rnd <= rnd + 7'd1;
            end
          end
        end
        ST_FOLD: begin
          // add the working words into the chain; a..e restart from it
          h[0] <= h[0] + a;
          h[1] <= h[1] + b;
          h[2] <= h[2] + c;
          h[3] <= h[3] + d;
          h[4] <= h[4] + e;
          a    <= h[0] + a;
          b    <= h[1] + b;
          c    <= h[2] + c;
          d    <= h[3] + d;
          e    <= h[4] + e;
          oidx <= 3'd0;
          state <= msg_end ? ST_EMIT : ST_ROUND;
        end
        default: begin
          if (!out_valid || out_ch.ready) begin
            out_valid <= 1'b1;
            if (oidx == LAST_IDX) begin
              // digest out, start the next message
              a <= sha1_pkg::H_INIT[0];
              b <= sha1_pkg::H_INIT[1];
              c <= sha1_pkg::H_INIT[2];
              d <= sha1_pkg::H_INIT[3];
              e <= sha1_pkg::H_INIT[4];
              for (int i = 0; i < 5; i++) begin
                h[i] <= sha1_pkg::H_INIT[i];
              end
              state <= ST_ROUND;
            end else begin
              oidx <= oidx + 3'd1;
            end
          end
        end
      endcase
    end
  end

  assign out_ch.valid       = out_valid;
  assign out_ch.digest_word = out_word;
  assign out_ch.word_index  = out_index;
  assign out_ch.last_word   = out_last;

endmodule

`default_nettype wire

// ===== rtl/core/sha1_stream_hasher.sv =====
`default_nettype none

// SHA-1 hasher over a byte stream. Each input word carries one byte (used when
// byte_valid is 1) and a last_byte flag; a last word closes the message, and the
// five digest words H0..H4 come out in order, last_word set on H4. The packer
// takes one byte per cycle while the word queue (QUEUE_DEPTH entries) has room
// and no padding is under way. The compression core runs one round per cycle,
// waiting on the queue in rounds 0..15, then a fold step, per 64-byte block.
// While rounds 16..79 and the fold run, the packer gets only QUEUE_DEPTH words
// ahead, so the rate on a long message is set by the round loop together with
// the queue depth. Closing a message adds padding words up to the end of a
// block, spilling into one more block when the length does not fit, and the
// five digest words go out through the output register; bytes of the next
// message are packed meanwhile until the queue fills.
module sha1_stream_hasher #(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire        clk,
  input  wire        rst,
  sha1_in_if.sink    in_ch,
  sha1_out_if.source out_ch
);

  logic                  q_push;
  sha1_pkg::sha1_qword_t q_push_data;
  logic                  q_full;
  logic                  q_pop;
  logic                  q_valid;
  sha1_pkg::sha1_qword_t q_data;

  sha1_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .q_full    (q_full),
    .push      (q_push),
    .push_data (q_push_data)
  );

  sha1_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_push_data),
    .full      (q_full),
    .pop       (q_pop),
    .q_valid   (q_valid),
    .q_data    (q_data)
  );

  sha1_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_data  (q_data),
    .pop     (q_pop),
    .out_ch  (out_ch)
  );

endmodule

`default_nettype wire
